### sv/sdf_pkg.sv
// Shared types and constants for the signed decimal formatter.
package sdf_pkg;

  localparam int unsigned MAG_W              = 32;
  localparam int unsigned BCD_DIGITS         = 10;
  localparam int unsigned DCNT_W             = 4;
  localparam int unsigned DEFAULT_MAX_DIGITS = 10;
  localparam int unsigned BIT_CNT_W          = $clog2(MAG_W);

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [3:0] DIGIT_NINE = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } sdf_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic sel_sign;
    logic next_digit;
  } sdf_cmd_t;

  typedef struct packed {
    logic ndig_zero;
    logic rem_one;
  } sdf_status_t;

endpackage

### sv/signed_decimal_formatter.sv
// Signed decimal formatter: signed 32-bit value to fixed-width ASCII characters.
// Usage:
//   Input stream (s_axis): one transaction carries a value and a digit count.
//   Output stream (m_axis): one transaction per character: the sign ('-' or
//   space) followed by the digit count's number of decimal digits, most
//   significant first, with leading zeros. tlast marks the final character.
//   tuser flags overflow on every character of a number whose magnitude does
//   not fit the digit count; its digits are then all '9'. Counts above
//   MAX_DIGITS are saturated to MAX_DIGITS.
// Timing:
//   After an input transaction, the shift-add-3 converter processes the
//   magnitude, one magnitude bit per cycle, then the sign character is offered.
//   The next value is taken only when the previous number's last character
//   has left.
// Reset and stalls:
//   Reset returns the controller to idle with nothing pending. A stalled
//   receiver holds the current character steady until it is taken.
module signed_decimal_formatter import sdf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] digit_count, [39:36] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] character
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] overflow
);

  sdf_cmd_t    cmd;
  sdf_status_t status;

  sdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sdf_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .value_i       (s_axis_tdata[MAG_W-1:0]),
    .digit_count_i (s_axis_tdata[MAG_W+DCNT_W-1:MAG_W]),
    .cmd_i         (cmd),
    .status_o      (status),
    .character_o   (m_axis_tdata),
    .overflow_o    (m_axis_tuser)
  );

endmodule

### sv/sdf_datapath.sv
// Datapath: magnitude, shift-add-3 BCD conversion and character selection.
module sdf_datapath import sdf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                clk_i,
  input  logic [MAG_W-1:0]    value_i,
  input  logic [DCNT_W-1:0]   digit_count_i,
  input  sdf_cmd_t            cmd_i,
  output sdf_status_t         status_o,
  output logic [7:0]          character_o,
  output logic                overflow_o
);

  localparam int unsigned SH_W = BCD_DIGITS * 4 + MAG_W;

  logic [BCD_DIGITS-1:0][3:0] bcd_q, bcd_d, bcd_adj;
  logic [MAG_W-1:0]           mag_q, mag_d, mag_in;
  logic                       neg_q;
  logic [DCNT_W-1:0]          ndig_q, rem_q, n_sat, dig_idx;
  logic [SH_W-1:0]            shifted;
  logic [3:0]                 digit;
  logic                       ovf;

  assign n_sat  = (digit_count_i > DCNT_W'(MAX_DIGITS)) ? DCNT_W'(MAX_DIGITS) : digit_count_i;
  assign mag_in = value_i[MAG_W-1] ? (~value_i + MAG_W'(1)) : value_i;

  // One double-dabble step: correct digits of five or more, then shift in a bit.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
    shifted = {bcd_adj, mag_q} << 1;
    bcd_d   = shifted[SH_W-1:MAG_W];
    mag_d   = shifted[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bcd_q  <= '0;
      mag_q  <= mag_in;
      neg_q  <= value_i[MAG_W-1];
      ndig_q <= n_sat;
      rem_q  <= n_sat;
    end else if (cmd_i.step) begin
      bcd_q <= bcd_d;
      mag_q <= mag_d;
    end else if (cmd_i.next_digit) begin
      rem_q <= rem_q - DCNT_W'(1);
    end
  end

  // Overflow when any digit above the requested count is nonzero.
  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if ((i >= int'(ndig_q)) && (bcd_q[i] != 4'd0)) begin
        ovf = 1'b1;
      end
    end
  end

  assign dig_idx = rem_q - DCNT_W'(1);
  assign digit   = ovf ? DIGIT_NINE : bcd_q[dig_idx];

  always_comb begin
    if (cmd_i.sel_sign) begin
      character_o = neg_q ? CH_MINUS : CH_SPACE;
    end else begin
      character_o = CH_ZERO + {4'd0, digit};
    end
  end

  assign overflow_o         = ovf;
  assign status_o.ndig_zero = (ndig_q == DCNT_W'(0));
  assign status_o.rem_one   = (rem_q == DCNT_W'(1));

endmodule

### sv/sdf_ctrl.sv
// Controller: sequences conversion steps and the sign and digit transactions.
module sdf_ctrl import sdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_last_o,
  input  sdf_status_t status_i,
  output sdf_cmd_t    cmd_o
);

  sdf_state_e           state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic                 out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    bit_cnt_d    = bit_cnt_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    out_last_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        bit_cnt_d  = bit_cnt_q + BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(MAG_W - 1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        out_valid_o    = 1'b1;
        out_last_o     = status_i.ndig_zero;
        cmd_o.sel_sign = 1'b1;
        if (out_fire) begin
          state_d = status_i.ndig_zero ? ST_IDLE : ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        out_valid_o = 1'b1;
        out_last_o  = status_i.rem_one;
        if (out_fire) begin
          cmd_o.next_digit = 1'b1;
          if (status_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CONV && bit_cnt_q == '0))
    else $error("accepted item did not start conversion");

  a_sides_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a character is pending");

  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && bit_cnt_q == BIT_CNT_W'(MAG_W - 1)) |=> (state_q == ST_SIGN))
    else $error("conversion did not end after all bits");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last_o) |=> (state_q == ST_IDLE))
    else $error("block busy after last character");
`endif

endmodule
